[rtl/mean_and_std_deviation_defines.svh]
// Assertion macros shared by the checker of the mean and deviation block.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef MEAN_AND_STD_DEVIATION_DEFINES_SVH
`define MEAN_AND_STD_DEVIATION_DEFINES_SVH

// same-cycle implication
`define MSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/msd_pkg.sv]
// Shared widths, limits and controller/datapath interface types for the
// mean and deviation block. No dependencies.
package msd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int MAX_SAMPLES = 65536;
    localparam int CNT_W       = 17;
    localparam int SUM_W       = 33;
    localparam int SQ_W        = 48;
    localparam int SQR_W       = 2 * SAMPLE_W - 1;
    localparam int MEAN_W      = 16;
    localparam int STD_W       = 16;
    localparam int ROOT_W      = SQ_W / 2;
    localparam int DIV_STEPS   = SQ_W;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SAMPLES);

    typedef struct packed {
        logic acc;
        logic ld_mean;
        logic ld_sq;
        logic div_step;
        logic mul;
        logic var_ld;
        logic sq_ld;
        logic sq_step;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

[rtl/mean_and_std_deviation.sv]
// Top level of the population mean and standard deviation block.
// Depends on msd_pkg, msd_ctrl and msd_datapath.
//
//   channel | direction | handshake         | fields
//   --------+-----------+-------------------+--------------------------------------------
//   input   | in        | i_valid / o_stall | i_sample, i_last
//   result  | out       | o_valid / i_stall | o_sample_count, o_mean_value, o_std_dev,
//           |           |                   | o_overflowed
//
// A word without last is taken without a stall; samples stream back to back into the accumulators.
// A word with last starts the flush, the two passes of the bit-serial divider (mean, then
// mean of squares), the squaring multiply, the variance and the two-bits-per-cycle root
// unit; o_stall is high throughout.
// A stalled result holds the block in its final state until the output register frees.
// Reset is synchronous and active low; it clears the accumulators and the controller.
module mean_and_std_deviation import msd_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [CNT_W-1:0]           o_sample_count,
    output logic signed [MEAN_W-1:0]   o_mean_value,
    output logic [STD_W-1:0]           o_std_dev,
    output logic                       o_overflowed
);

    t_cmd    cmd;
    t_status status;

    msd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_last   (i_last),
        .o_stall  (o_stall),
        .o_cmd    (cmd),
        .i_status (status)
    );

    msd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample       (i_sample),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_sample_count (o_sample_count),
        .o_mean_value   (o_mean_value),
        .o_std_dev      (o_std_dev),
        .o_overflowed   (o_overflowed)
    );

endmodule

[rtl/msd_ctrl.sv]
// Sequencer for accumulation, the two shared divisions, the variance and the root.
// Depends on msd_pkg.
module msd_ctrl import msd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_last,
    output logic    o_stall,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    typedef enum logic [10:0] {
        S_ACC   = 11'b00000000001,
        S_FLUSH = 11'b00000000010,
        S_LDM   = 11'b00000000100,
        S_DIVM  = 11'b00000001000,
        S_LDS   = 11'b00000010000,
        S_DIVS  = 11'b00000100000,
        S_MUL   = 11'b00001000000,
        S_VAR   = 11'b00010000000,
        S_SQL   = 11'b00100000000,
        S_SQRT  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_ACC: begin
                o_cmd.acc = i_valid;
                if (i_valid && i_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_LDM;
            end
            S_LDM: begin
                o_cmd.ld_mean = 1'b1;
                n_step        = '0;
                n_state       = S_DIVM;
            end
            S_DIVM: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_LDS;
                end
            end
            S_LDS: begin
                o_cmd.ld_sq = 1'b1;
                n_step      = '0;
                n_state     = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_VAR;
            end
            S_VAR: begin
                o_cmd.var_ld = 1'b1;
                n_state      = S_SQL;
            end
            S_SQL: begin
                o_cmd.sq_ld = 1'b1;
                n_step      = '0;
                n_state     = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sq_step = 1'b1;
                n_step        = r_step + 1'b1;
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    assign o_stall = (r_state != S_ACC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

[rtl/msd_datapath.sv]
// Accumulators, shared restoring divider, squaring multiplier, root unit and
// output register of the mean and deviation block. Depends on msd_pkg.
module msd_datapath import msd_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic [CNT_W-1:0]           o_sample_count,
    output logic signed [MEAN_W-1:0]   o_mean_value,
    output logic [STD_W-1:0]           o_std_dev,
    output logic                       o_overflowed
);

    logic [CNT_W-1:0]           r_cnt;
    logic                       r_ovf;
    logic signed [SUM_W-1:0]    r_sum;
    logic [SQ_W-1:0]            r_sqs;
    logic                       r_p_valid;
    logic signed [SAMPLE_W-1:0] r_p_x;
    logic [SQR_W-1:0]           r_p_sq;
    logic signed [2*SAMPLE_W-1:0] sq_full;

    logic [SQ_W-1:0]  r_quo;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_dvs;
    logic             r_neg;
    logic [SUM_W-1:0] r_mmag;
    logic [63:0]      r_m2;
    logic [SQ_W-1:0]  r_var;
    logic [CNT_W:0]   div_t;
    logic [SUM_W-1:0] abs_sum;
    logic [SUM_W-1:0] mean_full;

    logic [SQ_W-1:0]       r_rad;
    logic [ROOT_W+1:0]     r_srem;
    logic [ROOT_W-1:0]     r_root;
    logic [ROOT_W+3:0]     sq_rp;
    logic [ROOT_W+3:0]     sq_trial;

    logic                     r_out_valid;
    logic [CNT_W-1:0]         r_o_cnt;
    logic signed [MEAN_W-1:0] r_o_mean;
    logic [STD_W-1:0]         r_o_std;
    logic                     r_o_ovf;

    assign sq_full   = i_sample * i_sample;
    assign abs_sum   = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
    assign div_t     = {r_rem, r_quo[SQ_W-1]};
    assign sq_rp     = {r_srem, r_rad[SQ_W-1 -: 2]};
    assign sq_trial  = {2'b00, r_root, 2'b01};
    assign mean_full = r_neg ? (~r_mmag + 1'b1) : r_mmag;
    assign o_status.out_free = !r_out_valid || !i_stall;

    // accumulate: square in stage one, add in stage two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_sum     <= '0;
            r_sqs     <= '0;
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= 1'b0;
            if (i_cmd.acc) begin
                if (r_cnt == MAX_COUNT) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt     <= r_cnt + 1'b1;
                    r_p_valid <= 1'b1;
                end
            end
            if (r_p_valid) begin
                r_sum <= r_sum + SUM_W'(r_p_x);
                r_sqs <= r_sqs + SQ_W'(r_p_sq);
            end
            if (i_cmd.out_ld) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
                r_sum <= '0;
                r_sqs <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_p_x  <= i_sample;
            r_p_sq <= sq_full[SQR_W-1:0];
        end
    end

    // divider, variance and root
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_mean) begin
            r_quo <= SQ_W'(abs_sum);
            r_rem <= '0;
            r_dvs <= r_cnt;
            r_neg <= r_sum[SUM_W-1];
        end
        if (i_cmd.ld_sq) begin
            r_mmag <= r_quo[SUM_W-1:0];
            r_quo  <= r_sqs;
            r_rem  <= '0;
        end
        if (i_cmd.div_step) begin
            if (div_t >= {1'b0, r_dvs}) begin
                r_rem <= CNT_W'(div_t - {1'b0, r_dvs});
                r_quo <= {r_quo[SQ_W-2:0], 1'b1};
            end else begin
                r_rem <= div_t[CNT_W-1:0];
                r_quo <= {r_quo[SQ_W-2:0], 1'b0};
            end
        end
        if (i_cmd.mul) begin
            r_m2 <= r_mmag[31:0] * r_mmag[31:0];
        end
        if (i_cmd.var_ld) begin
            if (!r_mmag[SUM_W-1] && ({16'b0, r_quo} > r_m2)) begin
                r_var <= r_quo - r_m2[SQ_W-1:0];
            end else begin
                r_var <= '0;
            end
        end
        if (i_cmd.sq_ld) begin
            r_rad  <= r_var;
            r_srem <= '0;
            r_root <= '0;
        end
        if (i_cmd.sq_step) begin
            r_rad <= {r_rad[SQ_W-3:0], 2'b00};
            if (sq_rp >= sq_trial) begin
                r_srem <= (ROOT_W+2)'(sq_rp - sq_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_srem <= sq_rp[ROOT_W+1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // output word: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_o_cnt  <= r_cnt;
            r_o_mean <= mean_full[MEAN_W-1:0];
            r_o_std  <= r_root[STD_W-1:0];
            r_o_ovf  <= r_ovf;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample_count = r_o_cnt;
    assign o_mean_value   = r_o_mean;
    assign o_std_dev      = r_o_std;
    assign o_overflowed   = r_o_ovf;

endmodule

[rtl/msd_checker.sv]
// Port-level checks of the mean and deviation block, bound to its top level.
// Depends on msd_pkg and mean_and_std_deviation_defines.svh.
`include "mean_and_std_deviation_defines.svh"

module msd_checker import msd_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       i_last,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [CNT_W-1:0]           o_sample_count,
    input logic signed [MEAN_W-1:0]   o_mean_value,
    input logic [STD_W-1:0]           o_std_dev,
    input logic                       o_overflowed
);

    `MSD_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_mean_value) && $stable(o_std_dev), "stalled result word changed")
    `MSD_ASSERT_NXT(a_busy_after_last, i_valid && !o_stall && i_last, o_stall, "input not stalled after last word")
    `MSD_ASSERT_IMP(a_count_nonzero, o_valid, o_sample_count != '0, "result word with zero count")
    `MSD_ASSERT_IMP(a_std_range, o_valid, o_std_dev <= 16'h8000, "deviation out of range")
    `MSD_ASSERT_IMP(a_ovf_count, o_valid && o_overflowed, o_sample_count == MAX_COUNT, "overflow without saturated count")

endmodule

bind mean_and_std_deviation msd_checker u_msd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_last         (i_last),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_sample_count (o_sample_count),
    .o_mean_value   (o_mean_value),
    .o_std_dev      (o_std_dev),
    .o_overflowed   (o_overflowed)
);

[dv/msd_stats_checker.sv]
`timescale 1ns / 1ps
// Checker for mean_and_std_deviation. It tracks the sample stream, predicts the
// count, mean, deviation and overflow flag of each data set, and compares them with
// the result channel. Depends on msd_pkg.
module msd_stats_checker import msd_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_word_valid,
    input  logic                       i_word_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last,
    input  logic                       i_res_valid,
    input  logic                       i_res_stall,
    input  logic [CNT_W-1:0]           i_sample_count,
    input  logic signed [MEAN_W-1:0]   i_mean_value,
    input  logic [STD_W-1:0]           i_std_dev,
    input  logic                       i_overflowed,
    output int                         o_failures,
    output int                         o_pending,
    output int                         o_checked
);

    typedef struct packed {
        logic [CNT_W-1:0]         count;
        logic signed [MEAN_W-1:0] mean;
        logic [STD_W-1:0]         std_dev;
        logic                     overflowed;
    } t_set_stats;

    logic signed [SUM_W-1:0] sum_acc;
    logic [SQ_W-1:0]         squares_acc;
    logic [CNT_W-1:0]        count_acc;
    logic                    overflow_acc;
    t_set_stats              stats_queue[$];
    int                      failures;
    int                      checked;

    function automatic longint unsigned floor_root(input longint unsigned value);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= value) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic t_set_stats set_stats(input logic signed [SUM_W-1:0] sum,
                                             input logic [SQ_W-1:0] squares,
                                             input logic [CNT_W-1:0] count,
                                             input logic overflowed);
        longint          total;
        longint          n;
        longint          mean;
        longint unsigned mag;
        longint unsigned sq_mean;
        longint unsigned variance;
        longint unsigned root;
        t_set_stats      r;
        total    = sum;
        n        = count;
        mean     = (n != 0) ? total / n : 0;
        mag      = (mean < 0) ? -mean : mean;
        sq_mean  = (n != 0) ? longint'(squares) / n : 0;
        variance = 0;
        if (mag < (64'd1 << 32) && sq_mean > mag * mag) begin
            variance = sq_mean - mag * mag;
        end
        root         = floor_root(variance);
        r.count      = count;
        r.mean       = mean[MEAN_W-1:0];
        r.std_dev    = root[STD_W-1:0];
        r.overflowed = overflowed;
        return r;
    endfunction

    task automatic report_field(input string field, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        longint     smp;
        t_set_stats want;
        if (!i_rst_n) begin
            sum_acc      = '0;
            squares_acc  = '0;
            count_acc    = '0;
            overflow_acc = 1'b0;
            stats_queue.delete();
            failures     = 0;
            checked      = 0;
        end else begin
            if (i_word_valid && !i_word_stall) begin
                smp = i_sample;
                if (count_acc == MAX_COUNT) begin
                    overflow_acc = 1'b1;
                end else begin
                    sum_acc     = sum_acc + SUM_W'(smp);
                    squares_acc = squares_acc + SQ_W'(smp * smp);
                    count_acc   = count_acc + 1'b1;
                end
                if (i_last) begin
                    stats_queue.push_back(set_stats(sum_acc, squares_acc, count_acc,
                                                    overflow_acc));
                    sum_acc      = '0;
                    squares_acc  = '0;
                    count_acc    = '0;
                    overflow_acc = 1'b0;
                end
            end
            if (i_res_valid && !i_res_stall) begin
                checked++;
                if (stats_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual count %0d",
                             $time, i_sample_count);
                    failures++;
                end else begin
                    want = stats_queue.pop_front();
                    report_field("sample_count", want.count, i_sample_count);
                    report_field("mean_value", want.mean, i_mean_value);
                    report_field("std_dev", want.std_dev, i_std_dev);
                    report_field("overflowed", want.overflowed, i_overflowed);
                end
            end
        end
        o_failures <= failures;
        o_pending  <= stats_queue.size();
        o_checked  <= checked;
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Top of the mean_and_std_deviation testbench: clock, reset, sample stimulus and
// result-side stalls. Depends on msd_pkg, the block and msd_stats_checker.
module testbench import msd_pkg::*;;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       i_last = 1'b0;
    logic                       o_valid;
    logic                       i_stall = 1'b1;
    logic [CNT_W-1:0]           o_sample_count;
    logic signed [MEAN_W-1:0]   o_mean_value;
    logic [STD_W-1:0]           o_std_dev;
    logic                       o_overflowed;

    int failures;
    int pending;
    int checked;
    int words_sent = 0;
    int sets_sent = 0;
    bit in_quiet = 1'b0;
    bit out_quiet = 1'b0;

    mean_and_std_deviation uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample_count (o_sample_count),
        .o_mean_value   (o_mean_value),
        .o_std_dev      (o_std_dev),
        .o_overflowed   (o_overflowed)
    );

    msd_stats_checker stats_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word_valid   (i_valid),
        .i_word_stall   (o_stall),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_sample_count (o_sample_count),
        .i_mean_value   (o_mean_value),
        .i_std_dev      (o_std_dev),
        .i_overflowed   (o_overflowed),
        .o_failures     (failures),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic last,
                             input int unsigned gap);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= smp;
        i_last   <= last;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        words_sent++;
        if (last) begin
            sets_sent++;
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int base,
                                                              input bit clustered);
        if (clustered) begin
            return SAMPLE_W'(base + int'($urandom_range(0, 63)) - 32);
        end
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2, 3:    return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    initial begin : receiver
        int unsigned gap;
        int          taken;
        taken = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 8 == 0) begin
                out_quiet = ($urandom_range(0, 3) == 0);
            end
            gap = (taken == 60) ? 600 : draw_gap(out_quiet);
            if (gap == 0) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b1;
                do @(posedge i_clk); while (!o_valid);
                repeat (gap - 1) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            taken++;
        end
    end

    initial begin : stimulus
        int set_len;
        int base;
        bit clustered;
        int random_words;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(16'sh0000, 1'b1, draw_gap(1'b0));
        send_word(16'sh8000, 1'b1, draw_gap(1'b0));
        send_word(16'sh7fff, 1'b1, draw_gap(1'b0));
        send_word(16'sh8000, 1'b0, draw_gap(1'b0));
        send_word(16'sh7fff, 1'b1, draw_gap(1'b0));
        send_word(16'sh7fff, 1'b0, draw_gap(1'b0));
        send_word(16'sh8000, 1'b1, draw_gap(1'b0));
        send_word(-16'sd1, 1'b0, draw_gap(1'b0));
        send_word(-16'sd2, 1'b1, draw_gap(1'b0));
        send_word(16'sh5555, 1'b0, draw_gap(1'b0));
        send_word(16'shaaaa, 1'b0, draw_gap(1'b0));
        send_word(16'sh0001, 1'b0, draw_gap(1'b0));
        send_word(16'sh7ffe, 1'b1, draw_gap(1'b0));
        repeat (3) send_word(16'sh0123, 1'b0, draw_gap(1'b0));
        send_word(16'sh0123, 1'b1, draw_gap(1'b0));

        random_words = 0;
        while (random_words < 1530) begin
            set_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                    : $urandom_range(1, 12);
            clustered = ($urandom_range(0, 2) == 0);
            base      = int'($urandom_range(0, 65535)) - 32768;
            for (int i = 0; i < set_len; i++) begin
                if (random_words % 24 == 0) begin
                    in_quiet = ($urandom_range(0, 3) == 0);
                end
                send_word(pick_sample(base, clustered), i == set_len - 1, draw_gap(in_quiet));
                random_words++;
            end
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Streamed %0d samples in %0d data sets, extreme and clustered values among them;",
                 words_sent, sets_sent);
        $display("%0d results compared, one long result-side hold-off included.", checked);
        if (failures == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #15_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[mean_and_std_deviation.f]
+incdir+rtl
rtl/msd_pkg.sv
rtl/msd_ctrl.sv
rtl/msd_datapath.sv
rtl/mean_and_std_deviation.sv
rtl/msd_checker.sv
dv/msd_stats_checker.sv
dv/testbench.sv
